[hdl/jaf_pkg.sv]
// ----------------------------------------------------------------------------
// jaf_pkg: shared widths and register indexes for the junction active force
// Word and radicand widths used by the top level and by the square root
// and divider pipelines, and the configuration register indexes.
// ----------------------------------------------------------------------------
package jaf_pkg;

   localparam int DATA_W     = 32;
   localparam int RAD_W      = 64;
   localparam int ROOT_W     = 32;
   localparam int SQRT_STEPS = 32;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USE_CELL_TYPE    = 3'd0,
      CSR_SYMMETRIC_MYOSIN = 3'd1,
      CSR_SMALL_THRESHOLD  = 3'd2,
      CSR_BETA_TYPE0       = 3'd3,
      CSR_BETA_TYPE1       = 3'd4,
      CSR_ALPHA_TYPE0      = 3'd5,
      CSR_ALPHA_TYPE1      = 3'd6
   } csr_index_type;

   // An index past the register list; writes to it are dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_UNUSED = 3'd7;

endpackage

[hdl/jaf_isqrt.sv]
// ----------------------------------------------------------------------------
// jaf_isqrt: pipelined integer square root
// floor(sqrt(radicand)) of a 64-bit value, one result bit per stage,
// SQRT_STEPS register stages; the whole pipe advances on enable.
// ----------------------------------------------------------------------------
module jaf_isqrt
   import jaf_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0] rem_ff [SQRT_STEPS];
   logic [RAD_W-1:0] res_ff [SQRT_STEPS];
   logic [RAD_W-1:0] rem_in [SQRT_STEPS];
   logic [RAD_W-1:0] res_in [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << (RAD_W - 2 - 2 * j);
      logic [RAD_W-1:0] rem_src;
      logic [RAD_W-1:0] res_src;
      logic [RAD_W-1:0] trial;

      if (j == 0) begin : g_first
         assign rem_src = radicand;
         assign res_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign res_src = res_ff[j-1];
      end

      assign trial = res_src + STEP_BIT;

      always_comb begin
         if (rem_src >= trial) begin
            rem_in[j] = rem_src - trial;
            res_in[j] = (res_src >> 1) + STEP_BIT;
         end else begin
            rem_in[j] = rem_src;
            res_in[j] = res_src >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < SQRT_STEPS; i++) begin
            rem_ff[i] <= rem_in[i];
            res_ff[i] <= res_in[i];
         end
      end
   end

   assign root = res_ff[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

[hdl/jaf_udiv.sv]
// ----------------------------------------------------------------------------
// jaf_udiv: pipelined restoring divider
// quotient = floor(dividend * 2^(QBITS-1) / divisor) for a dividend no
// larger than the divisor; one quotient bit per stage, QBITS stages.
// ----------------------------------------------------------------------------
module jaf_udiv
   import jaf_pkg::*;
#(
   parameter int QBITS = 17
)
(
   input  logic              clock,
   input  logic              enable,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic [QBITS-1:0]  quotient
);

   logic [DATA_W-1:0] rem_ff [QBITS];
   logic [DATA_W-1:0] den_ff [QBITS];
   logic [QBITS-1:0]  quo_ff [QBITS];
   logic [DATA_W-1:0] rem_in [QBITS];
   logic [DATA_W-1:0] den_in [QBITS];
   logic [QBITS-1:0]  quo_in [QBITS];

   for (genvar j = 0; j < QBITS; j++) begin : g_step
      logic [DATA_W-1:0] rem_src;
      logic [DATA_W-1:0] den_src;
      logic [QBITS-1:0]  quo_src;
      logic              next_bit;
      logic [DATA_W:0]   trial;
      logic [DATA_W:0]   diff;

      // The first step shifts in the last dividend bit; the rest shift in zeros.
      if (j == 0) begin : g_first
         assign rem_src  = {1'b0, dividend[DATA_W-1:1]};
         assign next_bit = dividend[0];
         assign den_src  = divisor;
         assign quo_src  = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign next_bit = 1'b0;
         assign den_src  = den_ff[j-1];
         assign quo_src  = quo_ff[j-1];
      end

      assign trial = {rem_src, next_bit};
      assign diff  = trial - {1'b0, den_src};

      always_comb begin
         den_in[j] = den_src;
         if (trial >= {1'b0, den_src}) begin
            rem_in[j] = diff[DATA_W-1:0];
            quo_in[j] = quo_src | (QBITS'(1) << (QBITS - 1 - j));
         end else begin
            rem_in[j] = trial[DATA_W-1:0];
            quo_in[j] = quo_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < QBITS; i++) begin
            rem_ff[i] <= rem_in[i];
            den_ff[i] <= den_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign quotient = quo_ff[QBITS-1];

endmodule

[hdl/junction_active_force.sv]
// ----------------------------------------------------------------------------
// junction_active_force: active contractile force of one cell junction
// Selects and screens the contractility and length coefficients, then
// returns f times the unit edge vector in fixed point with saturation.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Word
//   req      in         req_valid / req_stall   edge vector, cell flags,
//                                               coefficients, myosin
//   rsp      out        rsp_valid / rsp_stall   force_x, force_y, zero_length
//   csr      in         csr_we                  register index and data
//
// One word enters per cycle while the pipeline advances; a result passes
// through the 32-stage square root, the FRAC_BITS+1 stage divider and the
// multiplier stages around them. Reset clears the valid bits and loads the
// register reset values. A stalled result freezes the whole pipeline; a
// word is still taken in the cycle the held result leaves.
// ----------------------------------------------------------------------------
module junction_active_force
   import jaf_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_edge_dx,
   input  logic signed [DATA_W-1:0] req_edge_dy,
   input  logic                     req_near_cell_outer,
   input  logic                     req_far_cell_outer,
   input  logic                     req_near_cell_type,
   input  logic                     req_far_cell_type,
   input  logic signed [DATA_W-1:0] req_near_beta,
   input  logic signed [DATA_W-1:0] req_far_beta,
   input  logic signed [DATA_W-1:0] req_near_alpha,
   input  logic signed [DATA_W-1:0] req_far_alpha,
   input  logic signed [DATA_W-1:0] req_near_myosin,
   input  logic signed [DATA_W-1:0] req_far_myosin,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_force_x,
   output logic signed [DATA_W-1:0] rsp_force_y,
   output logic                     rsp_zero_length
);

   localparam int F    = FRAC_BITS;
   localparam int MW   = DATA_W + 1;          // myosin after offset
   localparam int PW   = DATA_W + MW;         // beta times myosin
   localparam int GW   = 2 * DATA_W - F;      // scaled myosin sum g
   localparam int AW   = DATA_W + 1;          // alpha sum
   localparam int KPW  = 2 * AW;              // alpha sum times length
   localparam int KW   = KPW - F;             // length factor k
   localparam int FW   = DATA_W + 1 + F;      // saturated force magnitude
   localparam int UW   = F + 2;               // unit vector component
   localparam int QW   = F + 1;               // divider quotient
   localparam int HW   = (FW - DATA_W) + UW;  // high partial product
   localparam int LW   = (DATA_W + 1) + UW;   // low partial product
   localparam int PRW  = FW + UW;             // full projection product
   localparam int RW   = PRW - F;             // projection after scaling
   localparam int THR_W = DATA_W - 1;

   localparam logic signed [MW-1:0] MYO_HALF = MW'(1) <<< (F - 1);
   localparam logic signed [KW-1:0] K_ONE    = KW'(1) <<< F;
   localparam logic [FW-2:0]        F_LIMIT  = (FW-1)'(1) << (DATA_W - 1 + F);
   localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic                     valid;
      logic signed [GW-1:0]     g;
      logic signed [AW-1:0]     asum;
      logic signed [DATA_W-1:0] dx;
      logic signed [DATA_W-1:0] dy;
   } root_side_type;

   typedef struct packed {
      logic                 valid;
      logic signed [FW-1:0] f;
      logic                 sx;
      logic                 sy;
      logic                 zero;
   } div_side_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic                     use_type_ff;
   logic                     sym_ff;
   logic [THR_W-1:0]         thr_ff;
   logic signed [DATA_W-1:0] beta0_ff, beta1_ff, alpha0_ff, alpha1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_type_ff <= 1'b0;
         sym_ff      <= 1'b0;
         thr_ff      <= THR_W'(1);
         beta0_ff    <= '0;
         beta1_ff    <= '0;
         alpha0_ff   <= '0;
         alpha1_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_USE_CELL_TYPE:    use_type_ff <= csr_wdata[0];
            CSR_SYMMETRIC_MYOSIN: sym_ff      <= csr_wdata[0];
            CSR_SMALL_THRESHOLD:  thr_ff      <= csr_wdata[THR_W-1:0];
            CSR_BETA_TYPE0:       beta0_ff    <= csr_wdata;
            CSR_BETA_TYPE1:       beta1_ff    <= csr_wdata;
            CSR_ALPHA_TYPE0:      alpha0_ff   <= csr_wdata;
            CSR_ALPHA_TYPE1:      alpha1_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline moves as one unless a held result blocks the output.
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ------------------------------------------------------------------
   // Stage 1: coefficient selection, outer cells, myosin offset
   // ------------------------------------------------------------------
   logic signed [DATA_W-1:0] b1_in, b2_in, a1_in, a2_in;
   logic signed [MW-1:0]     m1_in, m2_in;

   always_comb begin
      if (use_type_ff) begin
         b1_in = req_near_cell_type ? beta1_ff  : beta0_ff;
         b2_in = req_far_cell_type  ? beta1_ff  : beta0_ff;
         a1_in = req_near_cell_type ? alpha1_ff : alpha0_ff;
         a2_in = req_far_cell_type  ? alpha1_ff : alpha0_ff;
      end else begin
         b1_in = req_near_beta;
         b2_in = req_far_beta;
         a1_in = req_near_alpha;
         a2_in = req_far_alpha;
      end
      if (req_near_cell_outer) begin
         b1_in = '0;
         a1_in = '0;
      end
      if (req_far_cell_outer) begin
         b2_in = '0;
         a2_in = '0;
      end
      m1_in = MW'(req_near_myosin);
      m2_in = MW'(req_far_myosin);
      if (sym_ff) begin
         m1_in = m1_in - MYO_HALF;
         m2_in = m2_in - MYO_HALF;
      end
   end

   logic                     s1_v_ff;
   logic signed [DATA_W-1:0] s1_dx_ff, s1_dy_ff, s1_b1_ff, s1_b2_ff, s1_a1_ff, s1_a2_ff;
   logic signed [MW-1:0]     s1_m1_ff, s1_m2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dx_ff <= req_edge_dx;
         s1_dy_ff <= req_edge_dy;
         s1_b1_ff <= b1_in;
         s1_b2_ff <= b2_in;
         s1_a1_ff <= a1_in;
         s1_a2_ff <= a2_in;
         s1_m1_ff <= m1_in;
         s1_m2_ff <= m2_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: small-contractility screen, alpha sum, edge squares
   // ------------------------------------------------------------------
   logic [DATA_W-1:0]          b1_mag, b2_mag;
   logic                       small1, small2;
   logic signed [DATA_W-1:0]   b1z_in, b2z_in;
   logic signed [AW-1:0]       asum_in;
   logic signed [2*DATA_W-1:0] dxsq_in, dysq_in;

   always_comb begin
      b1_mag  = s1_b1_ff[DATA_W-1] ? DATA_W'(-s1_b1_ff) : DATA_W'(s1_b1_ff);
      b2_mag  = s1_b2_ff[DATA_W-1] ? DATA_W'(-s1_b2_ff) : DATA_W'(s1_b2_ff);
      small1  = b1_mag < {1'b0, thr_ff};
      small2  = b2_mag < {1'b0, thr_ff};
      // A small near beta clears the far one, which then also counts as small.
      b2z_in  = small1 ? '0 : s1_b2_ff;
      b1z_in  = (small1 || small2) ? '0 : s1_b1_ff;
      asum_in = AW'(s1_a1_ff) + AW'(s1_a2_ff);
      dxsq_in = s1_dx_ff * s1_dx_ff;
      dysq_in = s1_dy_ff * s1_dy_ff;
   end

   logic                       s2_v_ff;
   logic signed [DATA_W-1:0]   s2_b1_ff, s2_b2_ff, s2_dx_ff, s2_dy_ff;
   logic signed [MW-1:0]       s2_m1_ff, s2_m2_ff;
   logic signed [AW-1:0]       s2_asum_ff;
   logic signed [2*DATA_W-1:0] s2_dxsq_ff, s2_dysq_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_b1_ff   <= b1z_in;
         s2_b2_ff   <= b2z_in;
         s2_m1_ff   <= s1_m1_ff;
         s2_m2_ff   <= s1_m2_ff;
         s2_asum_ff <= asum_in;
         s2_dxsq_ff <= dxsq_in;
         s2_dysq_ff <= dysq_in;
         s2_dx_ff   <= s1_dx_ff;
         s2_dy_ff   <= s1_dy_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: myosin products and squared length
   // ------------------------------------------------------------------
   logic signed [PW-1:0] p1_in, p2_in;

   assign p1_in = s2_b1_ff * s2_m1_ff;
   assign p2_in = s2_b2_ff * s2_m2_ff;

   logic                     s3_v_ff;
   logic signed [PW-1:0]     s3_p1_ff, s3_p2_ff;
   logic [RAD_W-1:0]         s3_rad_ff;
   logic signed [AW-1:0]     s3_asum_ff;
   logic signed [DATA_W-1:0] s3_dx_ff, s3_dy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_p1_ff   <= p1_in;
         s3_p2_ff   <= p2_in;
         s3_rad_ff  <= $unsigned(s2_dxsq_ff) + $unsigned(s2_dysq_ff);
         s3_asum_ff <= s2_asum_ff;
         s3_dx_ff   <= s2_dx_ff;
         s3_dy_ff   <= s2_dy_ff;
      end
   end

   // ------------------------------------------------------------------
   // Square root, with g formed on the way in and carried alongside
   // ------------------------------------------------------------------
   logic signed [PW-1:0] psum;
   root_side_type        root_side_in;
   root_side_type        rs_ff [SQRT_STEPS];
   logic [ROOT_W-1:0]    root;

   // The sum of both products fits PW bits; g is floor(sum / 2^(F+1)).
   assign psum = s3_p1_ff + s3_p2_ff;

   always_comb begin
      root_side_in.valid = s3_v_ff;
      root_side_in.g     = psum[PW-1:F+1];
      root_side_in.asum  = s3_asum_ff;
      root_side_in.dx    = s3_dx_ff;
      root_side_in.dy    = s3_dy_ff;
   end

   jaf_isqrt u_isqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (s3_rad_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQRT_STEPS; i++) begin
            rs_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         rs_ff[0] <= root_side_in;
         for (int i = 1; i < SQRT_STEPS; i++) begin
            rs_ff[i] <= rs_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stages K1 and K2: length factor k = 1 + (a1 + a2) * len
   // ------------------------------------------------------------------
   logic signed [AW-1:0]     len_sx;
   logic                     k1_v_ff;
   logic signed [KPW-1:0]    k1_prod_ff;
   logic [ROOT_W-1:0]        k1_len_ff;
   logic signed [GW-1:0]     k1_g_ff;
   logic signed [DATA_W-1:0] k1_dx_ff, k1_dy_ff;

   assign len_sx = {1'b0, root};

   always_ff @(posedge clock) begin
      if (adv) begin
         k1_prod_ff <= rs_ff[SQRT_STEPS-1].asum * len_sx;
         k1_len_ff  <= root;
         k1_g_ff    <= rs_ff[SQRT_STEPS-1].g;
         k1_dx_ff   <= rs_ff[SQRT_STEPS-1].dx;
         k1_dy_ff   <= rs_ff[SQRT_STEPS-1].dy;
      end
   end

   logic                     k2_v_ff;
   logic signed [KW-1:0]     k2_k_ff;
   logic [ROOT_W-1:0]        k2_len_ff;
   logic signed [GW-1:0]     k2_g_ff;
   logic signed [DATA_W-1:0] k2_dx_ff, k2_dy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         k2_k_ff   <= $signed(k1_prod_ff[KPW-1:F]) + K_ONE;
         k2_len_ff <= k1_len_ff;
         k2_g_ff   <= k1_g_ff;
         k2_dx_ff  <= k1_dx_ff;
         k2_dy_ff  <= k1_dy_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stages M0..M4: f = floor(g * k / 2^F), saturated, as 64x64 magnitudes
   // ------------------------------------------------------------------
   logic                m0_v_ff;
   logic [RAD_W-1:0]    m0_gmag_ff, m0_kmag_ff;
   logic                m0_neg_ff, m0_sx_ff, m0_sy_ff;
   logic [ROOT_W-1:0]   m0_len_ff;
   logic [DATA_W-1:0]   m0_dxm_ff, m0_dym_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m0_gmag_ff <= k2_g_ff[GW-1] ? RAD_W'($unsigned(-k2_g_ff)) : RAD_W'($unsigned(k2_g_ff));
         m0_kmag_ff <= k2_k_ff[KW-1] ? RAD_W'($unsigned(-k2_k_ff)) : RAD_W'($unsigned(k2_k_ff));
         m0_neg_ff  <= k2_g_ff[GW-1] ^ k2_k_ff[KW-1];
         m0_len_ff  <= k2_len_ff;
         m0_sx_ff   <= k2_dx_ff[DATA_W-1];
         m0_sy_ff   <= k2_dy_ff[DATA_W-1];
         m0_dxm_ff  <= k2_dx_ff[DATA_W-1] ? DATA_W'(-k2_dx_ff) : DATA_W'(k2_dx_ff);
         m0_dym_ff  <= k2_dy_ff[DATA_W-1] ? DATA_W'(-k2_dy_ff) : DATA_W'(k2_dy_ff);
      end
   end

   logic                m1_v_ff;
   logic [RAD_W-1:0]    m1_pp00_ff, m1_pp01_ff, m1_pp10_ff, m1_pp11_ff;
   logic                m1_neg_ff, m1_sx_ff, m1_sy_ff;
   logic [ROOT_W-1:0]   m1_len_ff;
   logic [DATA_W-1:0]   m1_dxm_ff, m1_dym_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_pp00_ff <= m0_gmag_ff[DATA_W-1:0]       * m0_kmag_ff[DATA_W-1:0];
         m1_pp01_ff <= m0_gmag_ff[DATA_W-1:0]       * m0_kmag_ff[RAD_W-1:DATA_W];
         m1_pp10_ff <= m0_gmag_ff[RAD_W-1:DATA_W]   * m0_kmag_ff[DATA_W-1:0];
         m1_pp11_ff <= m0_gmag_ff[RAD_W-1:DATA_W]   * m0_kmag_ff[RAD_W-1:DATA_W];
         m1_neg_ff  <= m0_neg_ff;
         m1_len_ff  <= m0_len_ff;
         m1_sx_ff   <= m0_sx_ff;
         m1_sy_ff   <= m0_sy_ff;
         m1_dxm_ff  <= m0_dxm_ff;
         m1_dym_ff  <= m0_dym_ff;
      end
   end

   logic                m2_v_ff;
   logic [RAD_W:0]      m2_mid_ff;
   logic [RAD_W-1:0]    m2_pp00_ff, m2_pp11_ff;
   logic                m2_neg_ff, m2_sx_ff, m2_sy_ff;
   logic [ROOT_W-1:0]   m2_len_ff;
   logic [DATA_W-1:0]   m2_dxm_ff, m2_dym_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_mid_ff  <= {1'b0, m1_pp01_ff} + {1'b0, m1_pp10_ff};
         m2_pp00_ff <= m1_pp00_ff;
         m2_pp11_ff <= m1_pp11_ff;
         m2_neg_ff  <= m1_neg_ff;
         m2_len_ff  <= m1_len_ff;
         m2_sx_ff   <= m1_sx_ff;
         m2_sy_ff   <= m1_sy_ff;
         m2_dxm_ff  <= m1_dxm_ff;
         m2_dym_ff  <= m1_dym_ff;
      end
   end

   logic                m3_v_ff;
   logic [2*RAD_W-1:0]  m3_full_ff;
   logic                m3_neg_ff, m3_sx_ff, m3_sy_ff;
   logic [ROOT_W-1:0]   m3_len_ff;
   logic [DATA_W-1:0]   m3_dxm_ff, m3_dym_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_full_ff <= {m2_pp11_ff, m2_pp00_ff} + ((2*RAD_W)'(m2_mid_ff) << DATA_W);
         m3_neg_ff  <= m2_neg_ff;
         m3_len_ff  <= m2_len_ff;
         m3_sx_ff   <= m2_sx_ff;
         m3_sy_ff   <= m2_sy_ff;
         m3_dxm_ff  <= m2_dxm_ff;
         m3_dym_ff  <= m2_dym_ff;
      end
   end

   logic                 f_sat, f_rnd;
   logic [FW-2:0]        f_qinc, f_mag;
   logic signed [FW-1:0] f_in;

   always_comb begin
      // Quotients at or above the limit saturate; negative results round down.
      f_sat  = |m3_full_ff[2*RAD_W-1:DATA_W-1+2*F];
      f_rnd  = |m3_full_ff[F-1:0];
      f_qinc = {1'b0, m3_full_ff[DATA_W-2+2*F:F]} + (FW-1)'(m3_neg_ff & f_rnd);
      f_mag  = f_sat ? F_LIMIT : f_qinc;
      f_in   = m3_neg_ff ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
   end

   logic                 m4_v_ff;
   logic signed [FW-1:0] m4_f_ff;
   logic                 m4_sx_ff, m4_sy_ff, m4_zero_ff;
   logic [ROOT_W-1:0]    m4_len_ff;
   logic [DATA_W-1:0]    m4_dxm_ff, m4_dym_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m4_f_ff    <= f_in;
         m4_zero_ff <= m3_len_ff == '0;
         m4_len_ff  <= m3_len_ff;
         m4_sx_ff   <= m3_sx_ff;
         m4_sy_ff   <= m3_sy_ff;
         m4_dxm_ff  <= m3_dxm_ff;
         m4_dym_ff  <= m3_dym_ff;
      end
   end

   // ------------------------------------------------------------------
   // Unit vector: |d| * 2^F / len, one quotient bit per stage
   // ------------------------------------------------------------------
   logic [QW-1:0] qx, qy;
   div_side_type  div_side_in;
   div_side_type  ds_ff [QW];

   jaf_udiv #(.QBITS(QW)) u_div_x (
      .clock    (clock),
      .enable   (adv),
      .dividend (m4_dxm_ff),
      .divisor  (m4_len_ff),
      .quotient (qx)
   );

   jaf_udiv #(.QBITS(QW)) u_div_y (
      .clock    (clock),
      .enable   (adv),
      .dividend (m4_dym_ff),
      .divisor  (m4_len_ff),
      .quotient (qy)
   );

   always_comb begin
      div_side_in.valid = m4_v_ff;
      div_side_in.f     = m4_f_ff;
      div_side_in.sx    = m4_sx_ff;
      div_side_in.sy    = m4_sy_ff;
      div_side_in.zero  = m4_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QW; i++) begin
            ds_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         ds_ff[0] <= div_side_in;
         for (int i = 1; i < QW; i++) begin
            ds_ff[i] <= ds_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage U: signed unit vector (division truncates toward zero)
   // ------------------------------------------------------------------
   logic signed [UW-1:0] ux_pos, uy_pos;
   logic                 u_v_ff, u_zero_ff;
   logic signed [UW-1:0] u_x_ff, u_y_ff;
   logic signed [FW-1:0] u_f_ff;

   assign ux_pos = $signed({1'b0, qx});
   assign uy_pos = $signed({1'b0, qy});

   always_ff @(posedge clock) begin
      if (adv) begin
         u_x_ff    <= ds_ff[QW-1].sx ? -ux_pos : ux_pos;
         u_y_ff    <= ds_ff[QW-1].sy ? -uy_pos : uy_pos;
         u_f_ff    <= ds_ff[QW-1].f;
         u_zero_ff <= ds_ff[QW-1].zero;
      end
   end

   // ------------------------------------------------------------------
   // Stages P1, P2: floor(f * u / 2^F), f split at bit 32
   // ------------------------------------------------------------------
   logic signed [FW-DATA_W-1:0] f_hi;
   logic signed [DATA_W:0]      f_lo;

   assign f_hi = u_f_ff[FW-1:DATA_W];
   assign f_lo = {1'b0, u_f_ff[DATA_W-1:0]};

   logic                 p1_v_ff, p1_zero_ff;
   logic signed [HW-1:0] p1_hx_ff, p1_hy_ff;
   logic signed [LW-1:0] p1_lx_ff, p1_ly_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_hx_ff   <= f_hi * u_x_ff;
         p1_hy_ff   <= f_hi * u_y_ff;
         p1_lx_ff   <= f_lo * u_x_ff;
         p1_ly_ff   <= f_lo * u_y_ff;
         p1_zero_ff <= u_zero_ff;
      end
   end

   logic                  p2_v_ff, p2_zero_ff;
   logic signed [PRW-1:0] p2_tx_ff, p2_ty_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_tx_ff   <= (PRW'(p1_hx_ff) <<< DATA_W) + PRW'(p1_lx_ff);
         p2_ty_ff   <= (PRW'(p1_hy_ff) <<< DATA_W) + PRW'(p1_ly_ff);
         p2_zero_ff <= p1_zero_ff;
      end
   end

   // ------------------------------------------------------------------
   // Output register: scale, saturate, zero-length override
   // ------------------------------------------------------------------
   logic signed [RW-1:0]     rx, ry;
   logic signed [DATA_W-1:0] fx_in, fy_in;

   assign rx = p2_tx_ff[PRW-1:F];
   assign ry = p2_ty_ff[PRW-1:F];

   always_comb begin
      if (&rx[RW-1:DATA_W-1] || ~|rx[RW-1:DATA_W-1]) begin
         fx_in = rx[DATA_W-1:0];
      end else begin
         fx_in = rx[RW-1] ? S32_MIN : S32_MAX;
      end
      if (&ry[RW-1:DATA_W-1] || ~|ry[RW-1:DATA_W-1]) begin
         fy_in = ry[DATA_W-1:0];
      end else begin
         fy_in = ry[RW-1] ? S32_MIN : S32_MAX;
      end
      if (p2_zero_ff) begin
         fx_in = '0;
         fy_in = '0;
      end
   end

   logic                     rsp_valid_ff, rsp_zero_ff;
   logic signed [DATA_W-1:0] rsp_fx_ff, rsp_fy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_fx_ff   <= fx_in;
         rsp_fy_ff   <= fy_in;
         rsp_zero_ff <= p2_zero_ff;
      end
   end

   // Valid bits of the named stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         k1_v_ff      <= 1'b0;
         k2_v_ff      <= 1'b0;
         m0_v_ff      <= 1'b0;
         m1_v_ff      <= 1'b0;
         m2_v_ff      <= 1'b0;
         m3_v_ff      <= 1'b0;
         m4_v_ff      <= 1'b0;
         u_v_ff       <= 1'b0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff      <= req_valid;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         k1_v_ff      <= rs_ff[SQRT_STEPS-1].valid;
         k2_v_ff      <= k1_v_ff;
         m0_v_ff      <= k2_v_ff;
         m1_v_ff      <= m0_v_ff;
         m2_v_ff      <= m1_v_ff;
         m3_v_ff      <= m2_v_ff;
         m4_v_ff      <= m3_v_ff;
         u_v_ff       <= ds_ff[QW-1].valid;
         p1_v_ff      <= u_v_ff;
         p2_v_ff      <= p1_v_ff;
         rsp_valid_ff <= p2_v_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_force_x     = rsp_fx_ff;
   assign rsp_force_y     = rsp_fy_ff;
   assign rsp_zero_length = rsp_zero_ff;

endmodule
